FILE: rtl/core/dmd_pkg.sv
package dmd_pkg;

  localparam int YEAR_BITS   = 16;
  localparam int COUNT_BITS  = 16;
  localparam int DAY_BITS    = 5;
  localparam int MONTH_BITS  = 4;
  localparam int STATUS_BITS = 2;

  localparam int REM_BITS    = 9;
  localparam int REM_MOD     = 400;

  // year mod 400 is 16 * ((year >> 4) mod 25) + the low four year bits
  localparam int YHI_BITS    = YEAR_BITS - 4;
  localparam int REM_MOD_HI  = REM_MOD / 16;
  localparam int RECIP_SHIFT = YEAR_BITS + 1;
  localparam int RECIP_BITS  = YEAR_BITS - 3;
  localparam logic [RECIP_BITS-1:0] RECIP_HI =
    RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'(REM_MOD_HI - 1)) / 64'(REM_MOD_HI));

  localparam logic [MONTH_BITS-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_BITS-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_BITS-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_BITS-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_BITS-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_BITS-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_BITS-1:0] MONTH_DEC = 4'd12;

  localparam logic [DAY_BITS-1:0] LEN_LONG  = 5'd31;
  localparam logic [DAY_BITS-1:0] LEN_SHORT = 5'd30;
  localparam logic [DAY_BITS-1:0] LEN_LEAP  = 5'd29;
  localparam logic [DAY_BITS-1:0] LEN_FEB   = 5'd28;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_UNDER   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_CHECK,
    S_STEP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic set_invalid;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic mod_done;
    logic date_ok;
    logic step_done;
  } stat_t;

  // rem is the year modulo 400
  function automatic logic is_leap(input logic [REM_BITS-1:0] rem);
    logic century;
    century = (rem == REM_BITS'(100)) || (rem == REM_BITS'(200)) ||
              (rem == REM_BITS'(300));
    return (rem[1:0] == 2'b00) && !century;
  endfunction

  function automatic logic [DAY_BITS-1:0] month_len(input logic [MONTH_BITS-1:0] m,
                                                   input logic leap);
    logic [DAY_BITS-1:0] len;
    case (m) inside
      MONTH_FEB:                                   len = leap ? LEN_LEAP : LEN_FEB;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV:  len = LEN_SHORT;
      default:                                     len = LEN_LONG;
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/core/dmd_ctrl.sv
module dmd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  dmd_pkg::stat_t  stat,
  output dmd_pkg::cmd_t   cmd
);

  dmd_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dmd_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dmd_pkg::S_IDLE:  if (in_valid) state_nxt = dmd_pkg::S_MOD;
      dmd_pkg::S_MOD:   if (stat.mod_done) state_nxt = dmd_pkg::S_CHECK;
      dmd_pkg::S_CHECK: state_nxt = stat.date_ok ? dmd_pkg::S_STEP : dmd_pkg::S_DONE;
      dmd_pkg::S_STEP:  if (stat.step_done) state_nxt = dmd_pkg::S_DONE;
      dmd_pkg::S_DONE:  if (!out_stall) state_nxt = dmd_pkg::S_IDLE;
      default:          state_nxt = dmd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      dmd_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      dmd_pkg::S_MOD:   cmd.mod_step    = !stat.mod_done;
      dmd_pkg::S_CHECK: cmd.set_invalid = !stat.date_ok;
      dmd_pkg::S_STEP:  cmd.step        = !stat.step_done;
      dmd_pkg::S_DONE:  out_valid       = 1'b1;
      default:          cmd = '0;
    endcase
  end

  a_load_to_mod: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == dmd_pkg::S_MOD)
    else $error("load did not start the year reduction");

  a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command");

endmodule

FILE: rtl/core/dmd_datapath.sv
module dmd_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  dmd_pkg::cmd_t                      cmd,
  output dmd_pkg::stat_t                     stat,
  input  logic [dmd_pkg::DAY_BITS-1:0]       in_day,
  input  logic [dmd_pkg::MONTH_BITS-1:0]     in_month,
  input  logic [dmd_pkg::YEAR_BITS-1:0]      in_year,
  input  logic [dmd_pkg::COUNT_BITS-1:0]     in_days_back,
  output logic [dmd_pkg::DAY_BITS-1:0]       out_result_day,
  output logic [dmd_pkg::MONTH_BITS-1:0]     out_result_month,
  output logic [dmd_pkg::YEAR_BITS-1:0]      out_result_year,
  output logic [dmd_pkg::STATUS_BITS-1:0]    out_status
);

  localparam int YB = dmd_pkg::YEAR_BITS;
  localparam int RB = dmd_pkg::REM_BITS;
  localparam int HB = dmd_pkg::YHI_BITS;

  logic [dmd_pkg::DAY_BITS-1:0]    day_r, day_nxt;
  logic [dmd_pkg::MONTH_BITS-1:0]  month_r, month_nxt;
  logic [YB-1:0]                   year_r, year_nxt;
  logic [dmd_pkg::COUNT_BITS-1:0]  count_r, count_nxt;
  logic                            mod_done_r, mod_done_nxt;
  logic [RB-1:0]                   rem_r, rem_nxt;
  dmd_pkg::status_t                status_r, status_nxt;

  logic [HB-1:0]                   year_hi;
  logic [HB+dmd_pkg::RECIP_BITS-1:0] recip_prod;
  logic [HB-1:0]                   quot_hi;
  logic [HB-1:0]                   rem_hi;
  logic [RB-1:0]                   year_rem;
  logic                            leap;
  logic [dmd_pkg::DAY_BITS-1:0]    cur_len;
  logic [dmd_pkg::DAY_BITS-1:0]    prev_len;
  logic                            at_origin;

  // year mod 400 by reciprocal multiplication on the year above its low four bits
  assign year_hi    = year_r[YB-1:4];
  assign recip_prod = year_hi * dmd_pkg::RECIP_HI;
  assign quot_hi    = HB'(recip_prod[dmd_pkg::RECIP_SHIFT +: HB-4]);
  assign rem_hi     = year_hi - quot_hi * HB'(dmd_pkg::REM_MOD_HI);
  assign year_rem   = {rem_hi[RB-5:0], year_r[3:0]};

  assign leap      = dmd_pkg::is_leap(rem_r);
  assign cur_len   = dmd_pkg::month_len(month_r, leap);
  assign prev_len  = dmd_pkg::month_len(month_r - 4'd1, leap);
  assign at_origin = (day_r == 5'd1) && (month_r == dmd_pkg::MONTH_JAN) &&
                     (year_r == YB'(1));

  assign stat.mod_done  = mod_done_r;
  assign stat.date_ok   = (month_r >= dmd_pkg::MONTH_JAN) && (month_r <= dmd_pkg::MONTH_DEC) &&
                          (year_r != '0) && (day_r != '0) && (day_r <= cur_len);
  assign stat.step_done = (count_r == '0) || (status_r == dmd_pkg::ST_UNDER);

  always_comb begin
    day_nxt      = day_r;
    month_nxt    = month_r;
    year_nxt     = year_r;
    count_nxt    = count_r;
    mod_done_nxt = mod_done_r;
    rem_nxt      = rem_r;
    status_nxt   = status_r;
    if (cmd.load) begin
      day_nxt      = in_day;
      month_nxt    = in_month;
      year_nxt     = in_year;
      count_nxt    = in_days_back;
      mod_done_nxt = 1'b0;
      rem_nxt      = '0;
      status_nxt   = dmd_pkg::ST_OK;
    end else if (cmd.mod_step) begin
      rem_nxt      = year_rem;
      mod_done_nxt = 1'b1;
    end else if (cmd.set_invalid) begin
      status_nxt = dmd_pkg::ST_INVALID;
    end else if (cmd.step) begin
      if (at_origin) begin
        status_nxt = dmd_pkg::ST_UNDER;
      end else begin
        count_nxt = count_r - 1'b1;
        if (day_r != 5'd1) begin
          day_nxt = day_r - 5'd1;
        end else if (month_r != dmd_pkg::MONTH_JAN) begin
          month_nxt = month_r - 4'd1;
          day_nxt   = prev_len;
        end else begin
          year_nxt  = year_r - 1'b1;
          month_nxt = dmd_pkg::MONTH_DEC;
          day_nxt   = dmd_pkg::LEN_LONG;
          rem_nxt   = (rem_r == '0) ? RB'(dmd_pkg::REM_MOD - 1) : rem_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_done_r <= 1'b0;
      rem_r      <= '0;
      status_r   <= dmd_pkg::ST_OK;
    end else begin
      mod_done_r <= mod_done_nxt;
      rem_r      <= rem_nxt;
      status_r   <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    day_r   <= day_nxt;
    month_r <= month_nxt;
    year_r  <= year_nxt;
    count_r <= count_nxt;
  end

  assign out_result_day   = day_r;
  assign out_result_month = month_r;
  assign out_result_year  = year_r;
  assign out_status       = status_r;

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r < RB'(dmd_pkg::REM_MOD))
    else $error("year residue out of range");

  a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> (count_r == $past(count_r) - 1'b1) || (status_r == dmd_pkg::ST_UNDER))
    else $error("day step did not consume the count");

  a_under_origin: assert property (@(posedge clk) disable iff (!rst_n)
    status_r == dmd_pkg::ST_UNDER |-> day_r == 5'd1 && month_r == dmd_pkg::MONTH_JAN &&
    year_r == YB'(1))
    else $error("underflow away from the origin date");

  a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> count_r != '0)
    else $error("step issued with nothing left to count");

endmodule

FILE: rtl/core/date_minus_days.sv
// date_minus_days: Gregorian date minus a count of days
//
// input channel: in_valid / in_stall with in_day, in_month, in_year and
// in_days_back. a request is taken when in_valid is high and in_stall low.
// only one request is in flight; in_stall stays high until its result is taken.
// result channel: out_valid / out_stall with out_result_day, out_result_month,
// out_result_year and out_status (0 ok, 1 invalid date echoed, 2 underflow,
// held at 1/1/1).
// sequence: after the accepting edge the year is reduced modulo 400, the
// date is checked, then the date steps back one day at a time until the
// count is used up (an invalid date skips the loop, an underflow stops at
// 1/1/1), and then out_valid rises.
// the next request is taken the cycle after the result is accepted, so
// requests are handled one at a time; the day stepping loop sets how often
// a new request can be taken.
// reset: synchronous active low rst_n returns the controller to idle with no
// result pending. a stalled result holds its value until out_stall drops.
module date_minus_days (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [dmd_pkg::DAY_BITS-1:0]       in_day,
  input  logic [dmd_pkg::MONTH_BITS-1:0]     in_month,
  input  logic [dmd_pkg::YEAR_BITS-1:0]      in_year,
  input  logic [dmd_pkg::COUNT_BITS-1:0]     in_days_back,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [dmd_pkg::DAY_BITS-1:0]       out_result_day,
  output logic [dmd_pkg::MONTH_BITS-1:0]     out_result_month,
  output logic [dmd_pkg::YEAR_BITS-1:0]      out_result_year,
  output logic [dmd_pkg::STATUS_BITS-1:0]    out_status
);

  dmd_pkg::cmd_t  cmd;
  dmd_pkg::stat_t stat;

  dmd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  dmd_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_day           (in_day),
    .in_month         (in_month),
    .in_year          (in_year),
    .in_days_back     (in_days_back),
    .out_result_day   (out_result_day),
    .out_result_month (out_result_month),
    .out_result_year  (out_result_year),
    .out_status       (out_status)
  );

endmodule

FILE: verif/tb_date_minus_days.sv
module tb_date_minus_days;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          DAYS_PER_400Y   = 146097;
  localparam int          DAYS_PER_100Y   = 36524;
  localparam int          DAYS_PER_4Y     = 1461;
  localparam int          DAYS_PER_YEAR   = 365;
  localparam int          MAX_STEP_CYCLES = (1 << dmd_pkg::COUNT_BITS) + 6;
  localparam int          WATCHDOG_LIMIT  = 4 * MAX_STEP_CYCLES;
  localparam int          END_SETTLE      = dmd_pkg::YEAR_BITS + 8;

  typedef logic [dmd_pkg::DAY_BITS-1:0]   day_t;
  typedef logic [dmd_pkg::MONTH_BITS-1:0] month_t;
  typedef logic [dmd_pkg::YEAR_BITS-1:0]  year_t;
  typedef logic [dmd_pkg::COUNT_BITS-1:0] count_t;

  typedef struct {
    day_t   day;
    month_t month;
    year_t  year;
    count_t days_back;
  } date_req_t;

  typedef struct {
    day_t             day;
    month_t           month;
    year_t            year;
    dmd_pkg::status_t status;
  } date_res_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  day_t                            in_day;
  month_t                          in_month;
  year_t                           in_year;
  count_t                          in_days_back;
  logic                            out_valid;
  logic                            out_stall;
  day_t                            out_result_day;
  month_t                          out_result_month;
  year_t                           out_result_year;
  logic [dmd_pkg::STATUS_BITS-1:0] out_status;

  date_res_t pending_dates[$];
  int        error_count   = 0;
  int        send_idle_pct = 0;
  int        stall_pct     = 0;
  int        hold_off_left = 0;
  int        quiet_cycles  = 0;

  date_minus_days u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_day           (in_day),
    .in_month         (in_month),
    .in_year          (in_year),
    .in_days_back     (in_days_back),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_day   (out_result_day),
    .out_result_month (out_result_month),
    .out_result_year  (out_result_year),
    .out_status       (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // calendar predictor

  function automatic bit leap_year(int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    if (m == dmd_pkg::MONTH_FEB)
      return leap_year(y) ? 32'(dmd_pkg::LEN_LEAP) : 32'(dmd_pkg::LEN_FEB);
    if (m == dmd_pkg::MONTH_APR || m == dmd_pkg::MONTH_JUN ||
        m == dmd_pkg::MONTH_SEP || m == dmd_pkg::MONTH_NOV)
      return 32'(dmd_pkg::LEN_SHORT);
    if (m >= dmd_pkg::MONTH_JAN && m <= dmd_pkg::MONTH_DEC) return 32'(dmd_pkg::LEN_LONG);
    return 0;
  endfunction

  // days since 1 january of year 1
  function automatic longint day_number(int unsigned d, int unsigned m, int unsigned y);
    longint p;
    longint n;
    p = longint'(y) - 1;
    n = p * DAYS_PER_YEAR + p / 4 - p / 100 + p / 400;
    for (int unsigned k = 32'(dmd_pkg::MONTH_JAN); k < m; k++)
      n += longint'(days_in_month(k, y));
    return n + longint'(d) - 1;
  endfunction

  function automatic date_res_t earlier_date(date_req_t r);
    date_res_t   res;
    longint      start;
    longint      rest;
    int unsigned q400, q100, q4, q1, y, m;
    if (r.year == 0 || r.day == 0 || r.day > days_in_month(r.month, r.year)) begin
      res.day    = r.day;
      res.month  = r.month;
      res.year   = r.year;
      res.status = dmd_pkg::ST_INVALID;
      return res;
    end
    start = day_number(r.day, r.month, r.year);
    if (longint'(r.days_back) > start) begin
      res.day    = day_t'(1);
      res.month  = dmd_pkg::MONTH_JAN;
      res.year   = year_t'(1);
      res.status = dmd_pkg::ST_UNDER;
      return res;
    end
    rest = start - longint'(r.days_back);
    q400 = 32'(rest / DAYS_PER_400Y);
    rest = rest % DAYS_PER_400Y;
    q100 = 32'(rest / DAYS_PER_100Y);
    if (q100 > 3) q100 = 3;
    rest = rest - longint'(q100) * DAYS_PER_100Y;
    q4   = 32'(rest / DAYS_PER_4Y);
    rest = rest % DAYS_PER_4Y;
    q1   = 32'(rest / DAYS_PER_YEAR);
    if (q1 > 3) q1 = 3;
    rest = rest - longint'(q1) * DAYS_PER_YEAR;
    y = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;
    m = 32'(dmd_pkg::MONTH_JAN);
    while (m < dmd_pkg::MONTH_DEC && rest >= longint'(days_in_month(m, y))) begin
      rest = rest - longint'(days_in_month(m, y));
      m++;
    end
    res.day    = day_t'(rest + 1);
    res.month  = month_t'(m);
    res.year   = year_t'(y);
    res.status = dmd_pkg::ST_OK;
    return res;
  endfunction

  // request driver

  task automatic send_date(input int unsigned d, input int unsigned m,
                           input int unsigned y, input int unsigned k);
    date_req_t req;
    req.day       = day_t'(d);
    req.month     = month_t'(m);
    req.year      = year_t'(y);
    req.days_back = count_t'(k);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_day       <= req.day;
    in_month     <= req.month;
    in_year      <= req.year;
    in_days_back <= req.days_back;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_dates.push_back(earlier_date(req));
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_dates.size() != 0);
  endtask

  function automatic date_req_t random_request();
    date_req_t   r;
    int unsigned y;
    int unsigned m;
    int unsigned len;
    int unsigned pick;
    case ($urandom_range(3))
      0: y = $urandom_range(1, 8);
      1: y = 100 * $urandom_range(1, 655) + $urandom_range(0, 2) - 1;
      2: y = $urandom_range(1, 65535);
      default: y = $urandom_range(1583, 2500);
    endcase
    m   = $urandom_range(32'(dmd_pkg::MONTH_JAN), 32'(dmd_pkg::MONTH_DEC));
    len = days_in_month(m, y);
    r.year  = year_t'(y);
    r.month = month_t'(m);
    r.day   = day_t'($urandom_range(1, len));
    pick = $urandom_range(99);
    if (pick < 4) r.days_back = count_t'($urandom_range(32768, 65535));
    else if (pick < 20) r.days_back = count_t'($urandom_range(0, 31));
    else r.days_back = count_t'($urandom_range(0, 1200));
    // mostly well-formed dates, the rest broken days or raw noise
    pick = $urandom_range(99);
    if (pick < 10) begin
      r.day   = day_t'($urandom_range(0, 31));
      r.month = month_t'($urandom_range(0, 15));
      r.year  = ($urandom_range(0, 3) == 0) ? '0 : year_t'($urandom_range(0, 65535));
    end else if (pick < 18) begin
      r.day = day_t'($urandom_range(len, 31) + (len < 31 ? 1 : 0));
    end
    return r;
  endfunction

  // tests

  task automatic test_exact_reach_and_underflow();
    send_date(1, dmd_pkg::MONTH_JAN, 1, 0);
    send_date(2, dmd_pkg::MONTH_JAN, 1, 1);
    send_date(31, dmd_pkg::MONTH_DEC, 1, 364);
    send_date(1, dmd_pkg::MONTH_JAN, 2, 365);
    send_date(1, dmd_pkg::MONTH_JAN, 1, 1);
    send_date(1, dmd_pkg::MONTH_JAN, 2, 366);
    send_date(10, 5, 100, 65535);
    wait_results_done();
  endtask

  task automatic test_leap_rules();
    send_date(1, 3, 2000, 1);
    send_date(1, 3, 1900, 1);
    send_date(1, 3, 2024, 1);
    send_date(1, 3, 2023, 1);
    send_date(1, dmd_pkg::MONTH_JAN, 2001, 1);
    send_date(29, dmd_pkg::MONTH_FEB, 2000, 0);
    wait_results_done();
  endtask

  task automatic test_invalid_dates();
    send_date(29, dmd_pkg::MONTH_FEB, 2001, 5);
    send_date(30, dmd_pkg::MONTH_FEB, 2000, 5);
    send_date(31, dmd_pkg::MONTH_APR, 2020, 5);
    send_date(15, 0, 2020, 5);
    send_date(15, 13, 2020, 5);
    send_date(31, 15, 65535, 65535);
    send_date(10, dmd_pkg::MONTH_JUN, 0, 5);
    send_date(0, dmd_pkg::MONTH_JUN, 2020, 5);
    wait_results_done();
  endtask

  task automatic test_field_extremes();
    send_date(31, dmd_pkg::MONTH_DEC, 65535, 65535);
    send_date(31, dmd_pkg::MONTH_DEC, 65535, 0);
    send_date(15, 8, 65535, 32768);
    wait_results_done();
  endtask

  task automatic test_random_requests(input int count, input int send_pct,
                                      input int recv_pct);
    date_req_t r;
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
    for (int i = 0; i < count; i++) begin
      r = random_request();
      send_date(r.day, r.month, r.year, r.days_back);
    end
    wait_results_done();
    send_idle_pct = 0;
    stall_pct     = 0;
  endtask

  task automatic test_back_pressure();
    // long receiver hold-off while requests keep coming
    hold_off_left = 500;
    send_date(5, 7, 2010, 3);
    send_date(1, 3, 2004, 2);
    send_date(20, 11, 1999, 40);
    send_date(1, dmd_pkg::MONTH_JAN, 3, 700);
    wait_results_done();
    send_date(12, 9, 1600, 10);
    wait_results_done();
    send_date(28, dmd_pkg::MONTH_FEB, 2100, 59);
    wait_results_done();
  endtask

  // result checker

  always @(posedge clk) begin : result_check
    date_res_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_dates.size() == 0) begin
        $display("%0t: unexpected result %0d/%0d/%0d status %0d", $time,
                 out_result_day, out_result_month, out_result_year, out_status);
        error_count++;
      end else begin
        want = pending_dates.pop_front();
        if (out_result_day !== want.day) begin
          $display("%0t: day expected %0d actual %0d", $time, want.day, out_result_day);
          error_count++;
        end
        if (out_result_month !== want.month) begin
          $display("%0t: month expected %0d actual %0d", $time, want.month,
                   out_result_month);
          error_count++;
        end
        if (out_result_year !== want.year) begin
          $display("%0t: year expected %0d actual %0d", $time, want.year,
                   out_result_year);
          error_count++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          error_count++;
        end
      end
    end
  end

  // receiver stall
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_left > 0) begin
        out_stall <= 1'b1;
        hold_off_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_day       <= '0;
    in_month     <= '0;
    in_year      <= '0;
    in_days_back <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_exact_reach_and_underflow();
    test_leap_rules();
    test_invalid_dates();
    test_field_extremes();
    test_random_requests(18, 0, 0);
    test_random_requests(18, 84, 0);
    test_random_requests(18, 0, 84);
    test_random_requests(18, 26, 26);
    test_back_pressure();

    repeat (END_SETTLE) @(posedge clk);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
